>>> design/pbsm_pkg.sv
package pbsm_pkg;

   localparam int POS_W       = 17;
   localparam int VAL_W       = 18;
   localparam int ROW_W       = 3;
   localparam int COL_W       = 6;
   localparam int KIND_W      = 2;
   localparam int HALF_W      = 3;
   localparam int DOF_W       = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 3;
   localparam int WIDE_W      = 26;

   localparam int DEF_MAX_HALF_MODES = 5;
   localparam int DEF_MAX_ROWS       = 6;
   localparam int QUEUE_DEPTH        = 2;
   localparam int BASIS_SLOTS        = 5;

   localparam logic [KIND_W-1:0] KIND_POWER    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHEB     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LEGENDRE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_BASIS_KIND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_MODES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DOF_COUNT  = 2'd2;

   localparam logic [POS_W-1:0] POS_ONE  = 17'd65536;
   localparam logic [POS_W-1:0] POS_HALF = 17'd32768;

   typedef logic signed [VAL_W-1:0] pbsm_value_type;

   localparam pbsm_value_type VAL_ONE  = 18'sd65536;
   localparam pbsm_value_type VAL_ZERO = 18'sd0;

   typedef struct packed {
      logic [POS_W-1:0]  x;
      logic              active;
      logic [KIND_W-1:0] kind;
      logic [HALF_W-1:0] half;
      logic [DOF_W-1:0]  rows;
   } pbsm_item_type;

   function automatic pbsm_value_type sat_q16(input logic signed [WIDE_W-1:0] v);
      pbsm_value_type r;
      if (v > 26'sd65536) begin
         r = VAL_ONE;
      end else if (v < -26'sd65536) begin
         r = -VAL_ONE;
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> design/pbsm_front.sv
module pbsm_front #(
   parameter int MAX_HALF_MODES = pbsm_pkg::DEF_MAX_HALF_MODES,
   parameter int MAX_ROWS       = pbsm_pkg::DEF_MAX_ROWS
) (
   input  logic                             push,
   output logic                             full,
   input  logic [pbsm_pkg::POS_W-1:0]       req_position,
   input  logic [pbsm_pkg::KIND_W-1:0]      cfg_kind,
   input  logic [pbsm_pkg::HALF_W-1:0]      cfg_half,
   input  logic [pbsm_pkg::DOF_W-1:0]       cfg_rows,
   input  logic                             queue_full,
   output logic                             queue_push,
   output pbsm_pkg::pbsm_item_type          queue_item
);
   import pbsm_pkg::*;

   localparam logic [HALF_W-1:0] HALF_MAX = HALF_W'(MAX_HALF_MODES);
   localparam logic [DOF_W-1:0]  ROWS_MAX = DOF_W'(MAX_ROWS);

   logic [POS_W-1:0]  s_clamp;
   logic [POS_W:0]    s_twice;
   logic [HALF_W-1:0] half_clamp;
   logic [DOF_W-1:0]  rows_clamp;
   logic              nonempty;

   always_comb begin
      s_clamp    = (req_position > POS_ONE) ? POS_ONE : req_position;
      s_twice    = {s_clamp, 1'b0};
      half_clamp = (cfg_half > HALF_MAX) ? HALF_MAX : cfg_half;
      rows_clamp = (cfg_rows > ROWS_MAX) ? ROWS_MAX : cfg_rows;
      nonempty   = (half_clamp != '0) && (rows_clamp != '0);

      queue_item.active = (s_clamp > POS_HALF);
      if (s_clamp < POS_HALF) begin
         queue_item.x = s_twice[POS_W-1:0];
      end else if (s_clamp == POS_HALF) begin
         queue_item.x = '0;
      end else begin
         queue_item.x = POS_W'(s_twice - {1'b0, POS_ONE});
      end
      queue_item.kind = cfg_kind;
      queue_item.half = half_clamp;
      queue_item.rows = rows_clamp;
   end

   // drop positions that give an empty matrix
   assign full       = queue_full;
   assign queue_push = push && !queue_full && nonempty;

endmodule

>>> design/pbsm_queue.sv
module pbsm_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  pbsm_pkg::pbsm_item_type wr_item,
   output logic                    q_full,
   input  logic                    rd_en,
   output pbsm_pkg::pbsm_item_type rd_item,
   output logic                    q_empty
);
   import pbsm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = PTR_W + 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

   pbsm_item_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign q_full  = (cnt_ff == DEPTH_CNT);
   assign q_empty = (cnt_ff == '0);
   assign rd_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

>>> design/pbsm_eval.sv
module pbsm_eval #(
   parameter int MAX_HALF_MODES = pbsm_pkg::DEF_MAX_HALF_MODES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  pbsm_pkg::pbsm_item_type q_item,
   output logic                    q_pop,
   output logic                    pat_valid,
   output pbsm_pkg::pbsm_item_type pat_item,
   output pbsm_pkg::pbsm_value_type pat_basis [MAX_HALF_MODES],
   input  logic                    pat_take
);
   import pbsm_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   localparam logic [2:0] STEP_FIRST = 3'd2;
   localparam logic [2:0] STEP_LAST  = 3'd4;

   logic [1:0]     state_ff, state_in;
   logic [2:0]     step_ff, step_in;
   pbsm_item_type  item_ff;
   pbsm_value_type t_ff;
   pbsm_value_type cur_ff;
   pbsm_value_type prev_ff;
   pbsm_value_type w_ff [1:4];

   logic signed [POS_W+1:0]   t_twice;
   pbsm_value_type            t_load;
   pbsm_value_type            cur_load;
   logic signed [VAL_W:0]     mul_b;
   logic signed [36:0]        prod;
   logic signed [36:0]        prod_rnd;
   logic signed [20:0]        rnd;
   logic signed [WIDE_W-1:0]  diff;
   pbsm_value_type            w_new;

   logic signed [WIDE_W-1:0]  l2_sum, l3_sum, l4_sum;
   logic signed [WIDE_W-1:0]  l2_val, l3_val, l4_val;
   pbsm_value_type            b_all [BASIS_SLOTS];

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign pat_valid = (state_ff == ST_HOLD);
   assign pat_item  = item_ff;

   always_comb begin
      t_twice  = $signed({1'b0, q_item.x, 1'b0}) - 19'sd65536;
      t_load   = t_twice[VAL_W-1:0];
      cur_load = (q_item.kind == KIND_POWER) ? $signed({1'b0, q_item.x}) : t_load;
   end

   always_comb begin
      case (item_ff.kind)
         KIND_POWER: mul_b = $signed({2'b00, item_ff.x});
         KIND_CHEB:  mul_b = $signed({t_ff, 1'b0});
         default:    mul_b = (VAL_W + 1)'(t_ff);
      endcase
      prod     = 37'(cur_ff) * 37'(mul_b);
      prod_rnd = prod + 37'sd32768;
      rnd      = prod_rnd[36:16];
      if (item_ff.kind == KIND_CHEB) begin
         diff = WIDE_W'(rnd) - WIDE_W'(prev_ff);
      end else begin
         diff = WIDE_W'(rnd);
      end
      w_new = sat_q16(diff);
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = ST_MUL;
               step_in  = STEP_FIRST;
            end
         end
         ST_MUL: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_HOLD;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_HOLD: begin
            if (pat_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_FIRST;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff  <= q_item;
         t_ff     <= t_load;
         cur_ff   <= cur_load;
         prev_ff  <= VAL_ONE;
         w_ff[1]  <= cur_load;
      end else if (state_ff == ST_MUL) begin
         prev_ff       <= cur_ff;
         cur_ff        <= w_new;
         w_ff[step_ff] <= w_new;
      end
   end

   // Legendre in t = 2x - 1 from the stored powers of t
   always_comb begin
      l2_sum = 26'sd3 * WIDE_W'(w_ff[2]) - 26'sd65536 + 26'sd1;
      l3_sum = 26'sd5 * WIDE_W'(w_ff[3]) - 26'sd3 * WIDE_W'(t_ff) + 26'sd1;
      l4_sum = 26'sd35 * WIDE_W'(w_ff[4]) - 26'sd30 * WIDE_W'(w_ff[2])
               + 26'sd196608 + 26'sd4;
      l2_val = l2_sum >>> 1;
      l3_val = l3_sum >>> 1;
      l4_val = l4_sum >>> 3;
   end

   always_comb begin
      case (item_ff.kind)
         KIND_POWER, KIND_CHEB: begin
            b_all[0] = VAL_ONE;
            b_all[1] = w_ff[1];
            b_all[2] = w_ff[2];
            b_all[3] = w_ff[3];
            b_all[4] = w_ff[4];
         end
         KIND_LEGENDRE: begin
            b_all[0] = VAL_ONE;
            b_all[1] = t_ff;
            b_all[2] = sat_q16(l2_val);
            b_all[3] = sat_q16(l3_val);
            b_all[4] = sat_q16(l4_val);
         end
         default: begin
            for (int i = 0; i < BASIS_SLOTS; i++) begin
               b_all[i] = VAL_ZERO;
            end
         end
      endcase
      for (int i = 0; i < MAX_HALF_MODES; i++) begin
         pat_basis[i] = b_all[i];
      end
   end

endmodule

>>> design/pbsm_emit.sv
module pbsm_emit #(
   parameter int MAX_HALF_MODES = pbsm_pkg::DEF_MAX_HALF_MODES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             pat_valid,
   input  pbsm_pkg::pbsm_item_type          pat_item,
   input  pbsm_pkg::pbsm_value_type         pat_basis [MAX_HALF_MODES],
   output logic                             pat_take,
   output logic                             empty,
   input  logic                             pop,
   output logic [pbsm_pkg::ROW_W-1:0]       rsp_row_index,
   output logic [pbsm_pkg::COL_W-1:0]       rsp_column_index,
   output pbsm_pkg::pbsm_value_type         rsp_entry_value,
   output logic                             rsp_last_entry
);
   import pbsm_pkg::*;

   localparam int IDX_W = (MAX_HALF_MODES > 1) ? $clog2(MAX_HALF_MODES) : 1;

   logic              busy_ff, busy_in;
   logic              out_valid_ff, out_valid_in;
   pbsm_value_type    basis_ff [MAX_HALF_MODES];
   logic              active_ff;
   logic [HALF_W-1:0] half_ff;
   logic [DOF_W-1:0]  rows_ff;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              seg_ff, seg_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [COL_W-1:0]  col_ff, col_in;

   logic [ROW_W-1:0]  out_row_ff;
   logic [COL_W-1:0]  out_col_ff;
   pbsm_value_type    out_val_ff;
   logic              out_last_ff;

   logic              advance;
   logic              idx_end;
   logic              last_now;
   pbsm_value_type    cur_val;

   assign advance  = busy_ff && (!out_valid_ff || pop);
   assign idx_end  = (HALF_W'(idx_ff) == half_ff - 3'd1);
   assign last_now = (row_ff == rows_ff - 3'd1) && seg_ff && idx_end;
   assign pat_take = pat_valid && (!busy_ff || (advance && last_now));
   assign cur_val  = (seg_ff == active_ff) ? basis_ff[idx_ff] : VAL_ZERO;

   assign empty            = !out_valid_ff;
   assign rsp_row_index    = out_row_ff;
   assign rsp_column_index = out_col_ff;
   assign rsp_entry_value  = out_val_ff;
   assign rsp_last_entry   = out_last_ff;

   always_comb begin
      busy_in = busy_ff;
      row_in  = row_ff;
      seg_in  = seg_ff;
      idx_in  = idx_ff;
      col_in  = col_ff;
      if (advance) begin
         col_in = col_ff + 6'd1;
         if (idx_end) begin
            idx_in = '0;
            if (seg_ff) begin
               seg_in = 1'b0;
               row_in = row_ff + 3'd1;
            end else begin
               seg_in = 1'b1;
            end
         end else begin
            idx_in = idx_ff + 1'b1;
         end
         if (last_now) begin
            busy_in = 1'b0;
         end
      end
      if (pat_take) begin
         busy_in = 1'b1;
         row_in  = '0;
         seg_in  = 1'b0;
         idx_in  = '0;
         col_in  = '0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         row_ff       <= '0;
         seg_ff       <= 1'b0;
         idx_ff       <= '0;
         col_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         row_ff       <= row_in;
         seg_ff       <= seg_in;
         idx_ff       <= idx_in;
         col_ff       <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pat_take) begin
         basis_ff  <= pat_basis;
         active_ff <= pat_item.active;
         half_ff   <= pat_item.half;
         rows_ff   <= pat_item.rows;
      end
      if (advance) begin
         out_row_ff  <= row_ff;
         out_col_ff  <= col_ff;
         out_val_ff  <= cur_val;
         out_last_ff <= last_now;
      end
   end

endmodule

>>> design/piecewise_basis_shape_matrix.sv
// Channel   Ports                                   Handshake
// input     push, full, req_position                taken when push && !full
// result    empty, pop, rsp_row_index,              taken when pop && !empty
//           rsp_column_index, rsp_entry_value,
//           rsp_last_entry
// config    csr_write_enable, csr_index, csr_data   written when csr_write_enable
//
// Each position gives rows * 2 * half_modes results at one per cycle while pop
// keeps the output register free; the result counter in the emitter sets the
// rate. The evaluator's one shared multiplier takes each position in steps
// (pop, three products, hand-off) and overlaps the previous position's emission.
// Synchronous reset empties the two-entry queue and sets basis_kind 0,
// half_modes 5, dof_count 6. full rises when the queue holds two positions;
// holding pop low stalls the emitter, then the evaluator, until the queue fills.
module piecewise_basis_shape_matrix #(
   parameter int MAX_HALF_MODES = pbsm_pkg::DEF_MAX_HALF_MODES,
   parameter int MAX_ROWS       = pbsm_pkg::DEF_MAX_ROWS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [pbsm_pkg::POS_W-1:0]         req_position,
   output logic                               empty,
   input  logic                               pop,
   output logic [pbsm_pkg::ROW_W-1:0]         rsp_row_index,
   output logic [pbsm_pkg::COL_W-1:0]         rsp_column_index,
   output pbsm_pkg::pbsm_value_type           rsp_entry_value,
   output logic                               rsp_last_entry,
   input  logic                               csr_write_enable,
   input  logic [pbsm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pbsm_pkg::CSR_DATA_W-1:0]    csr_data
);
   import pbsm_pkg::*;

   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [HALF_W-1:0] half_ff, half_in;
   logic [DOF_W-1:0]  dof_ff, dof_in;

   logic           queue_push;
   logic           queue_full;
   pbsm_item_type  queue_wr_item;
   logic           queue_pop;
   logic           queue_empty;
   pbsm_item_type  queue_rd_item;

   logic           pat_valid;
   logic           pat_take;
   pbsm_item_type  pat_item;
   pbsm_value_type pat_basis [MAX_HALF_MODES];

   always_comb begin
      kind_in = kind_ff;
      half_in = half_ff;
      dof_in  = dof_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_BASIS_KIND: kind_in = csr_data[KIND_W-1:0];
            REG_HALF_MODES: half_in = csr_data[HALF_W-1:0];
            REG_DOF_COUNT:  dof_in  = csr_data[DOF_W-1:0];
            default: begin
               kind_in = kind_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_POWER;
         half_ff <= 3'd5;
         dof_ff  <= 3'd6;
      end else begin
         kind_ff <= kind_in;
         half_ff <= half_in;
         dof_ff  <= dof_in;
      end
   end

   pbsm_front #(
      .MAX_HALF_MODES (MAX_HALF_MODES),
      .MAX_ROWS       (MAX_ROWS)
   ) u_front (
      .push         (push),
      .full         (full),
      .req_position (req_position),
      .cfg_kind     (kind_ff),
      .cfg_half     (half_ff),
      .cfg_rows     (dof_ff),
      .queue_full   (queue_full),
      .queue_push   (queue_push),
      .queue_item   (queue_wr_item)
   );

   pbsm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (queue_push),
      .wr_item (queue_wr_item),
      .q_full  (queue_full),
      .rd_en   (queue_pop),
      .rd_item (queue_rd_item),
      .q_empty (queue_empty)
   );

   pbsm_eval #(
      .MAX_HALF_MODES (MAX_HALF_MODES)
   ) u_eval (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (queue_empty),
      .q_item    (queue_rd_item),
      .q_pop     (queue_pop),
      .pat_valid (pat_valid),
      .pat_item  (pat_item),
      .pat_basis (pat_basis),
      .pat_take  (pat_take)
   );

   pbsm_emit #(
      .MAX_HALF_MODES (MAX_HALF_MODES)
   ) u_emit (
      .clock            (clock),
      .reset            (reset),
      .pat_valid        (pat_valid),
      .pat_item         (pat_item),
      .pat_basis        (pat_basis),
      .pat_take         (pat_take),
      .empty            (empty),
      .pop              (pop),
      .rsp_row_index    (rsp_row_index),
      .rsp_column_index (rsp_column_index),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_last_entry   (rsp_last_entry)
   );

endmodule
